// File: hw/rtl/mpqs_pkg.sv
// shared types and constants for the scanned min-priority queue
// no dependencies; imported by every module of the block
`default_nettype none

package mpqs_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned AGE_W    = IDX_W;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned TAG_W    = 16;
  localparam int unsigned OCC_W    = 5;

  typedef enum logic {
    FUNC_INSERT  = 1'b0,
    FUNC_EXTRACT = 1'b1
  } mpqs_func_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } mpqs_status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIND,
    ST_SCAN,
    ST_DRAIN,
    ST_REMOVE,
    ST_DONE
  } mpqs_state_e;

  typedef struct packed {
    logic             func;
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } mpqs_in_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [KEY_W-1:0] min_key;
    logic [TAG_W-1:0] min_tag;
    logic [OCC_W-1:0] occupancy;
  } mpqs_out_t;

  // one word of the entry store
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } mpqs_entry_t;

  // control from the sequencer to the compare unit
  typedef struct packed {
    logic clear;
    logic sample;
  } mpqs_scan_ctl_t;

  // slot bookkeeping that travels with a read beat
  typedef struct packed {
    logic             vld;
    logic [AGE_W-1:0] age;
    logic [IDX_W-1:0] idx;
  } mpqs_cand_t;

  typedef struct packed {
    logic             have;
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
    logic [AGE_W-1:0] age;
    logic [IDX_W-1:0] idx;
  } mpqs_best_t;

endpackage

`default_nettype wire

// File: hw/rtl/min_priority_queue_scan.sv
// min-priority queue over CAPACITY unsorted slots, one slot visited per cycle
// insert: free-slot walk from slot 0 to the lowest free slot, which is then written
// extract: one read and compare per slot, then drain, then removal of the minimum
// full/empty: answered from the held count; one item at a time, set by the single compare unit
// reset clears valid marks, count and handshake state; store contents stay
`default_nettype none

module min_priority_queue_scan
  import mpqs_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire mpqs_in_t  in_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output mpqs_out_t      out_o
);

  localparam logic [IDX_W-1:0] LastIdx = IDX_W'(CAPACITY - 1);

  mpqs_state_e      state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CAPACITY-1:0] valid_q, valid_d;
  logic [AGE_W-1:0] age_q [CAPACITY];
  logic [AGE_W-1:0] age_d [CAPACITY];
  mpqs_in_t         ins_q, ins_d;
  mpqs_out_t        res_q, res_d;
  mpqs_out_t        out_q;
  logic             out_valid_q;
  logic             pend_q, pend_d;
  mpqs_cand_t       cand_q;
  mpqs_scan_ctl_t   scan_ctl;
  mpqs_entry_t      rd_data;
  mpqs_best_t       best;
  logic             do_insert, do_remove, load_out;

  mpqs_entry_ram u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (do_insert),
    .wr_addr_i (idx_q),
    .wr_data_i ('{key: ins_q.key, tag: ins_q.tag}),
    .rd_addr_i (idx_q),
    .rd_data_o (rd_data)
  );

  mpqs_min_unit u_min (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (scan_ctl),
    .rd_data_i (rd_data),
    .cand_i    (cand_q),
    .best_o    (best)
  );

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    ins_d     = ins_q;
    res_d     = res_q;
    pend_d    = 1'b0;
    scan_ctl  = '0;
    do_insert = 1'b0;
    do_remove = 1'b0;
    load_out  = 1'b0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ins_d = in_i;
          idx_d = '0;
          res_d = '0;
          if (in_i.func == FUNC_EXTRACT) begin
            if (cnt_q == '0) begin
              res_d.status = STAT_EMPTY;
              state_d = ST_DONE;
            end else begin
              scan_ctl.clear = 1'b1;
              state_d = ST_SCAN;
            end
          end else begin
            if (cnt_q >= CNT_W'(CAPACITY)) begin
              res_d.status = STAT_FULL;
              state_d = ST_DONE;
            end else begin
              state_d = ST_FIND;
            end
          end
        end
      end
      ST_FIND: begin
        // lowest free slot; one is bound to exist since the queue is not full
        if (!valid_q[idx_q]) begin
          do_insert = 1'b1;
          res_d.status = STAT_OK;
          state_d = ST_DONE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_SCAN: begin
        pend_d = 1'b1;
        scan_ctl.sample = pend_q;
        if (idx_q == LastIdx) begin
          state_d = ST_DRAIN;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        scan_ctl.sample = pend_q;
        state_d = ST_REMOVE;
      end
      ST_REMOVE: begin
        do_remove = 1'b1;
        res_d.status  = STAT_OK;
        res_d.min_key = best.key;
        res_d.min_tag = best.tag;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // slot bookkeeping: ages stay dense ranks below CAPACITY
  always_comb begin
    valid_d = valid_q;
    cnt_d   = cnt_q;
    for (int i = 0; i < CAPACITY; i++) begin
      age_d[i] = age_q[i];
      if (do_insert) begin
        if (IDX_W'(i) == idx_q) begin
          age_d[i] = '0;
        end else if (valid_q[i]) begin
          age_d[i] = age_q[i] + 1'b1;
        end
      end else if (do_remove) begin
        if (valid_q[i] && (age_q[i] > best.age)) begin
          age_d[i] = age_q[i] - 1'b1;
        end
      end
    end
    if (do_insert) begin
      valid_d[idx_q] = 1'b1;
      cnt_d = cnt_q + 1'b1;
    end else if (do_remove) begin
      valid_d[best.idx] = 1'b0;
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      valid_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      valid_q <= valid_d;
      pend_q  <= pend_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    ins_q  <= ins_d;
    res_q  <= res_d;
    age_q  <= age_d;
    // slot marks travel alongside the registered store read
    cand_q <= '{vld: valid_q[idx_q], age: age_q[idx_q], idx: idx_q};
    if (load_out) begin
      out_q           <= res_q;
      out_q.occupancy <= OCC_W'(cnt_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_count_matches_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == CNT_W'($countones(valid_q)))
    else $error("held count differs from number of valid slots");

  a_find_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIND) |-> (cnt_q < CNT_W'(CAPACITY)))
    else $error("free-slot walk started on a full queue");

  a_remove_has_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_REMOVE) |-> (best.have && valid_q[best.idx]))
    else $error("removal without a valid minimum");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_insert |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("insert did not raise the held count");

endmodule

`default_nettype wire

// File: hw/rtl/mpqs_entry_ram.sv
// key/tag store of the queue, one write and one registered read per cycle
// depends on mpqs_pkg
`default_nettype none

module mpqs_entry_ram
  import mpqs_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        wr_en_i,
  input  wire logic [IDX_W-1:0] wr_addr_i,
  input  wire mpqs_entry_t wr_data_i,
  input  wire logic [IDX_W-1:0] rd_addr_i,
  output mpqs_entry_t      rd_data_o
);

  mpqs_entry_t mem_q [CAPACITY];
  mpqs_entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// File: hw/rtl/mpqs_min_unit.sv
// shared compare unit: keeps the running minimum over one scan
// depends on mpqs_pkg
`default_nettype none

module mpqs_min_unit
  import mpqs_pkg::*;
(
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire mpqs_scan_ctl_t ctl_i,
  input  wire mpqs_entry_t    rd_data_i,
  input  wire mpqs_cand_t     cand_i,
  output mpqs_best_t          best_o
);

  logic             have_q, have_d;
  logic [KEY_W-1:0] key_q, key_d;
  logic [TAG_W-1:0] tag_q, tag_d;
  logic [AGE_W-1:0] age_q, age_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             take;

  // on equal keys the younger entry (smaller age) wins
  always_comb begin
    take = ctl_i.sample && cand_i.vld &&
           (!have_q || (rd_data_i.key < key_q) ||
            ((rd_data_i.key == key_q) && (cand_i.age < age_q)));
    have_d = have_q;
    key_d  = key_q;
    tag_d  = tag_q;
    age_d  = age_q;
    idx_d  = idx_q;
    if (ctl_i.clear) begin
      have_d = 1'b0;
    end else if (take) begin
      have_d = 1'b1;
      key_d  = rd_data_i.key;
      tag_d  = rd_data_i.tag;
      age_d  = cand_i.age;
      idx_d  = cand_i.idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
    end else begin
      have_q <= have_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    tag_q <= tag_d;
    age_q <= age_d;
    idx_q <= idx_d;
  end

  assign best_o = '{have: have_q, key: key_q, tag: tag_q, age: age_q, idx: idx_q};

endmodule

`default_nettype wire
